// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the band peak level meter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset
`define BPLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define BPLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bplm_pkg.sv
// ---------------------------------------------------------------------------
// bplm_pkg
// Types and constants shared by the band peak level meter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bplm_pkg;

  // Channel slots held in the packed settings
  localparam int MAX_CH    = 4;
  localparam int CH_W      = 2;
  localparam int CCNT_W    = 3;

  // Field widths
  localparam int IDX_W     = 11;
  localparam int BIN_W     = 16;
  localparam int LVL_W     = 15;
  localparam int QUO_W     = 8;
  localparam int NUM_W     = LVL_W + QUO_W;
  localparam int STEP_W    = 3;
  localparam int IDXS_W    = MAX_CH * IDX_W;
  localparam int LVLS_W    = MAX_CH * LVL_W;

  // Stream and configuration port widths
  localparam int IN_DW     = 16;
  localparam int OUT_DW    = 16;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 60;

  localparam logic [QUO_W-1:0] FULL_SCALE = 8'd255;

  // Configuration register indices
  typedef enum logic [CFG_IW-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_BAND_BEGINS   = 3'd1,
    CFG_BAND_ENDS     = 3'd2,
    CFG_NOISE_LEVELS  = 3'd3,
    CFG_CEILINGS      = 3'd4
  } cfg_idx_t;

  // Frame-end sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_PUSH
  } seq_state_t;

  // Peak tracker control
  typedef struct packed {
    logic upd;
    logic clr;
  } bands_ctl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef logic [MAX_CH-1:0][BIN_W-1:0] peak_vec_t;

endpackage

`default_nettype wire

// File: rtl/bplm_bands.sv
// ---------------------------------------------------------------------------
// bplm_bands
// Bin counter and per-channel band peak tracking, one bin per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bplm_bands
  import bplm_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int FFT_BINS     = 1024
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  bands_ctl_t               ctl,
  input  wire  signed [BIN_W-1:0]  bin_value,
  input  wire         [IDXS_W-1:0] band_begins,
  input  wire         [IDXS_W-1:0] band_ends,
  output peak_vec_t                peak,
  output logic        [MAX_CH-1:0] seen
);

  localparam int CNT_W = $clog2(FFT_BINS + 1);

  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                     cnt_live;
  logic        [IDX_W-1:0]  cnt_x;
  peak_vec_t                peak_r, peak_nxt;
  logic        [MAX_CH-1:0] seen_r, seen_nxt;

  // Bins past the frame length belong to no band
  assign cnt_live = cnt_r < CNT_W'(FFT_BINS);
  assign cnt_x    = IDX_W'(cnt_r);

  // Counter: advance on a live bin, drop to zero at frame clear
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clr) begin
      cnt_nxt = '0;
    end else if (ctl.upd && cnt_live) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Lanes: take the bin as new peak when inside the band
  always_comb begin
    peak_nxt = peak_r;
    seen_nxt = seen_r;
    for (int k = 0; k < MAX_CH; k++) begin
      if (k < NUM_CHANNELS && ctl.upd && cnt_live &&
          cnt_x >= band_begins[k*IDX_W +: IDX_W] &&
          cnt_x <  band_ends[k*IDX_W +: IDX_W]) begin
        if (!seen_r[k] || bin_value > $signed(peak_r[k])) begin
          peak_nxt[k] = bin_value;
        end
        seen_nxt[k] = 1'b1;
      end
    end
    if (ctl.clr) begin
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
    end
  end

  // Peak values only count while their seen bit is set
  always_ff @(posedge clk) begin
    peak_r <= peak_nxt;
  end

  assign peak = peak_r;
  assign seen = seen_r;

endmodule

`default_nettype wire

// File: rtl/bplm_div.sv
// ---------------------------------------------------------------------------
// bplm_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bplm_div
  import bplm_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire  [NUM_W-1:0] num,
  input  wire  [LVL_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output div_sts_t         sts
);

  logic              busy_r, done_r;
  logic [NUM_W-1:0]  rem_r, dv_r;
  logic [QUO_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;
  logic              ge;
  logic [NUM_W-1:0]  rem_sub;

  // Trial subtract against the shifted divisor
  assign ge      = rem_r >= dv_r;
  assign rem_sub = rem_r - dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Load operands, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dv_r   <= NUM_W'(den) << (QUO_W - 1);
      q_r    <= '0;
      step_r <= STEP_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      q_r    <= {q_r[QUO_W-2:0], ge};
      dv_r   <= dv_r >> 1;
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign quo      = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

// File: rtl/band_peak_level_meter_top.sv
// ---------------------------------------------------------------------------
// band_peak_level_meter_top
// Per-channel band peak meter over spectrum frames, with brightness results.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one spectrum bin per beat, bin value in in_tdata, in_tlast on the
//           last bin of the frame. Bins are taken one per cycle while idle.
//   out_* : one brightness result per active channel after each frame end,
//           in channel order, out_tlast on the final one.
//   cfg_* : register writes (index, data), always ready; write only while
//           the block is idle.
// Frame end:
//   After the frame-end beat, in_tready stays low while the sequencer walks
//   the channels: a load step, the shared 8-step divider when the level is
//   not trivial, and a step to register the result, for each channel.
// Reset: registers, seen flags and the bin counter clear (not peaks); no output.
// Stall: a result waits in the output register; the sequencer holds until it
//   is taken. The next frame may start while the last result still waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module band_peak_level_meter_top
  import bplm_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int FFT_BINS     = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  // Input bins
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [IN_DW-1:0]  in_tdata,   // [15:0] bin_value
  input  wire               in_tlast,   // frame_end
  // Results
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [1:0] channel_index, [9:2] level, [15:10] zero
  output logic              out_tlast,  // last
  // Configuration writes
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [CFG_IW-1:0] cfg_index,
  input  wire  [CFG_DW-1:0] cfg_data
);

  // Configuration registers
  logic [CCNT_W-1:0] chan_cnt_r;
  logic [IDXS_W-1:0] begins_r, ends_r;
  logic [LVLS_W-1:0] noise_r, ceil_r;

  // Sequencer
  seq_state_t        state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [QUO_W-1:0]  lvl_r, lvl_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_chan_r;
  logic [QUO_W-1:0]  out_lvl_r;
  logic              out_last_r;

  // Datapath
  bands_ctl_t        bands_ctl;
  peak_vec_t         peak_vec;
  logic [MAX_CH-1:0] seen_vec;
  div_sts_t          div_sts;
  logic              div_start;
  logic [QUO_W-1:0]  div_quo;
  logic [NUM_W-1:0]  div_num;

  logic              in_acc, out_free, out_load, last_ch;
  logic [CCNT_W-1:0] active;
  logic signed [BIN_W-1:0] peak_sel, noise_ext, ceil_ext, diff;
  logic [LVL_W-1:0]  noise_sel, ceil_sel, diff_u;
  logic              le_noise, gt_ceil, trivial;
  logic [QUO_W-1:0]  trivial_lvl;

  // Configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= '0;
      begins_r   <= '0;
      ends_r     <= '0;
      noise_r    <= '0;
      ceil_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[CCNT_W-1:0];
        CFG_BAND_BEGINS:   begins_r   <= cfg_data[IDXS_W-1:0];
        CFG_BAND_ENDS:     ends_r     <= cfg_data[IDXS_W-1:0];
        CFG_NOISE_LEVELS:  noise_r    <= cfg_data[LVLS_W-1:0];
        CFG_CEILINGS:      ceil_r     <= cfg_data[LVLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Peak tracker
  bplm_bands #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FFT_BINS     (FFT_BINS)
  ) u_bands (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (bands_ctl),
    .bin_value   ($signed(in_tdata[BIN_W-1:0])),
    .band_begins (begins_r),
    .band_ends   (ends_r),
    .peak        (peak_vec),
    .seen        (seen_vec)
  );

  // Shared divider
  bplm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (ceil_sel),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  // Handshake and channel bookkeeping
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign active   = (chan_cnt_r > CCNT_W'(NUM_CHANNELS)) ? CCNT_W'(NUM_CHANNELS)
                                                         : chan_cnt_r;
  assign last_ch  = (CCNT_W'(ch_r) + CCNT_W'(1)) == active;

  // Select the current channel and classify its peak
  assign peak_sel  = $signed(peak_vec[ch_r]);
  assign noise_sel = noise_r[ch_r*LVL_W +: LVL_W];
  assign ceil_sel  = ceil_r[ch_r*LVL_W +: LVL_W];
  assign noise_ext = $signed({1'b0, noise_sel});
  assign ceil_ext  = $signed({1'b0, ceil_sel});
  assign le_noise  = peak_sel <= noise_ext;
  assign gt_ceil   = peak_sel > ceil_ext;
  assign trivial   = !seen_vec[ch_r] || le_noise || gt_ceil;
  assign trivial_lvl = (!seen_vec[ch_r] || le_noise) ? '0 : FULL_SCALE;

  // Numerator 255 * (peak - noise) as a shift and subtract
  assign diff    = peak_sel - noise_ext;
  assign diff_u  = diff[LVL_W-1:0];
  assign div_num = {diff_u, QUO_W'(0)} - NUM_W'(diff_u);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tlast && (active != '0)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = trivial ? S_PUSH : S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = last_ch ? S_IDLE : S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs; in idle the input is always ready, so a valid bin is a beat
  always_comb begin
    in_tready     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    bands_ctl.upd = 1'b0;
    bands_ctl.clr = 1'b0;
    ch_nxt        = ch_r;
    lvl_nxt       = lvl_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        bands_ctl.upd = in_tvalid;
        if (in_tvalid && in_tlast) begin
          ch_nxt        = '0;
          bands_ctl.clr = (active == '0);
        end
      end
      S_LOAD: begin
        div_start = !trivial;
        lvl_nxt   = trivial_lvl;
      end
      S_DIV: begin
        if (div_sts.done) begin
          lvl_nxt = div_quo;
        end
      end
      S_PUSH: begin
        out_load = out_free;
        if (out_free) begin
          bands_ctl.clr = last_ch;
          if (!last_ch) begin
            ch_nxt = ch_r + CH_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: hold until the beat is taken
  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    if (out_load) begin
      out_chan_r <= ch_r;
      out_lvl_r  <= lvl_r;
      out_last_r <= last_ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - CH_W - QUO_W)'(0), out_lvl_r, out_chan_r};
  assign out_tlast  = out_last_r;

  // Assertions
  `include "assert_macros.svh"

  `BPLM_ASSERT_ALWAYS(a_div_start_free, div_start |-> !div_sts.busy, "divider started while busy")
  `BPLM_ASSERT(a_ready_div_idle, in_tready |-> !div_sts.busy, "bin taken during a division")
  `BPLM_ASSERT(a_load_in_range, (state_r == S_LOAD) |-> (CCNT_W'(ch_r) < active), "channel past active count")
  `BPLM_ASSERT(a_push_clears, (out_load && last_ch) |=> !out_tvalid || out_tlast, "final result lost its last flag")

endmodule

`default_nettype wire
